### sv/piupt_pkg.sv
// Package with the item types, kind codes and fixed-point constants of the primitive tester.
package piupt_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 64 - FRAC_BITS;
	localparam int SUM_W     = PROD_W + 2;
	localparam int REM_W     = SUM_W + 1;

	localparam logic [2:0] KIND_CUBE     = 3'd0;
	localparam logic [2:0] KIND_CONE     = 3'd1;
	localparam logic [2:0] KIND_CYLINDER = 3'd2;
	localparam logic [2:0] KIND_SPHERE   = 3'd3;
	localparam logic [2:0] KIND_TORUS    = 3'd4;
	localparam logic [2:0] KIND_MESH     = 3'd5;

	localparam logic [1:0] REG_POINT_X = 2'd0;
	localparam logic [1:0] REG_POINT_Y = 2'd1;
	localparam logic [1:0] REG_POINT_Z = 2'd2;
	localparam logic [1:0] REG_POINT_W = 2'd3;

	localparam logic [31:0] POINT_W_RESET = 32'(1) << FRAC_BITS;

	typedef struct packed {
		logic [63:0] row0_left;
		logic [63:0] row0_right;
		logic [63:0] row1_left;
		logic [63:0] row1_right;
		logic [63:0] row2_left;
		logic [63:0] row2_right;
		logic [63:0] row3_left;
		logic [63:0] row3_right;
		logic [2:0]  primitive_kind;
		logic [15:0] object_number;
	} in_item_t;

	typedef struct packed {
		logic        inside_res;
		logic [15:0] object_index;
		logic        bad_kind;
	} res_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] obj;
		logic        w_zero;
		logic [2:0]  neg;
		logic [2:0]  half_ok;
	} meta_t;

endpackage

### sv/point_in_unit_primitive_test.sv
// Top level of the pipelined point-in-unit-primitive tester.
// The block takes one item per cycle and never asserts busy; each item's result appears on
// res_item with res_valid high for one cycle, at the end of the pipeline. The latency is set by
// the matrix multiply, the row sums, the operand preparation, a
// 16-stage restoring divider that yields one quotient bit per stage, a squaring stage and the
// final compare.
// The receiver cannot stall the block, so results are never held back.
module point_in_unit_primitive_test (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  piupt_pkg::in_item_t   in_item,
	output logic                  res_valid,
	output piupt_pkg::res_item_t  res_item,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int FB  = piupt_pkg::FRAC_BITS;
	localparam int PW  = piupt_pkg::PROD_W;
	localparam int SW  = piupt_pkg::SUM_W;
	localparam int RW  = piupt_pkg::REM_W;
	localparam int NST = FB;

	logic [31:0] pt_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pt_q[0] <= '0;
			pt_q[1] <= '0;
			pt_q[2] <= '0;
			pt_q[3] <= piupt_pkg::POINT_W_RESET;
		end else if (psel && penable && pwrite) begin
			pt_q[paddr[3:2]] <= pwdata;
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			piupt_pkg::REG_POINT_X: prdata = pt_q[0];
			piupt_pkg::REG_POINT_Y: prdata = pt_q[1];
			piupt_pkg::REG_POINT_Z: prdata = pt_q[2];
			piupt_pkg::REG_POINT_W: prdata = pt_q[3];
			default:                prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign busy   = 1'b0;

	logic accept;
	assign accept = start && !busy;

	logic [31:0] mat [4][4];
	always_comb begin
		mat[0][0] = in_item.row0_left[31:0];  mat[0][1] = in_item.row0_left[63:32];
		mat[0][2] = in_item.row0_right[31:0]; mat[0][3] = in_item.row0_right[63:32];
		mat[1][0] = in_item.row1_left[31:0];  mat[1][1] = in_item.row1_left[63:32];
		mat[1][2] = in_item.row1_right[31:0]; mat[1][3] = in_item.row1_right[63:32];
		mat[2][0] = in_item.row2_left[31:0];  mat[2][1] = in_item.row2_left[63:32];
		mat[2][2] = in_item.row2_right[31:0]; mat[2][3] = in_item.row2_right[63:32];
		mat[3][0] = in_item.row3_left[31:0];  mat[3][1] = in_item.row3_left[63:32];
		mat[3][2] = in_item.row3_right[31:0]; mat[3][3] = in_item.row3_right[63:32];
	end

	// Stage 1: sixteen products, each floored by dropping the fraction bits.
	logic signed [PW-1:0] prod_s1 [4][4];
	logic [2:0]           kind_s1;
	logic [15:0]          obj_s1;
	logic                 vld_s1;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[r][c] <= PW'((64'($signed(mat[r][c])) * 64'($signed(pt_q[c])))
					>>> FB);
			end
		end
		kind_s1 <= in_item.primitive_kind;
		obj_s1  <= in_item.object_number;
	end

	// Stage 2: row sums.
	logic signed [SW-1:0] h_s2 [4];
	logic [2:0]           kind_s2;
	logic [15:0]          obj_s2;
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			h_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1])
				+ SW'(prod_s1[r][2]) + SW'(prod_s1[r][3]);
		end
		kind_s2 <= kind_s1;
		obj_s2  <= obj_s1;
	end

	// Stage 3 and the divider: magnitudes, then one quotient bit per stage.
	logic [SW-1:0] abs_h [4];
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			abs_h[r] = h_s2[r][SW-1] ? SW'(-h_s2[r]) : SW'(h_s2[r]);
		end
	end

	logic [RW-1:0]  rem_sd  [NST+1][3];
	logic [RW-1:0]  den_sd  [NST+1];
	logic [FB-1:0]  quot_sd [NST+1][3];
	piupt_pkg::meta_t meta_sd [NST+1];
	logic [NST:0]   vld_sd;

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			rem_sd[0][a]  <= RW'(abs_h[a]);
			quot_sd[0][a] <= '0;
			meta_sd[0].neg[a]     <= h_s2[a][SW-1] ^ h_s2[3][SW-1];
			meta_sd[0].half_ok[a] <= {abs_h[a], 1'b0} < {1'b0, abs_h[3]};
		end
		den_sd[0]         <= RW'(abs_h[3]);
		meta_sd[0].kind   <= kind_s2;
		meta_sd[0].obj    <= obj_s2;
		meta_sd[0].w_zero <= (h_s2[3] == '0);
		for (int k = 1; k <= NST; k++) begin
			for (int a = 0; a < 3; a++) begin
				if ({rem_sd[k-1][a][RW-2:0], 1'b0} >= den_sd[k-1]) begin
					rem_sd[k][a]  <= {rem_sd[k-1][a][RW-2:0], 1'b0} - den_sd[k-1];
					quot_sd[k][a] <= {quot_sd[k-1][a][FB-2:0], 1'b1};
				end else begin
					rem_sd[k][a]  <= {rem_sd[k-1][a][RW-2:0], 1'b0};
					quot_sd[k][a] <= {quot_sd[k-1][a][FB-2:0], 1'b0};
				end
			end
			den_sd[k]  <= den_sd[k-1];
			meta_sd[k] <= meta_sd[k-1];
		end
	end

	// Squaring stage; only quotients below one half are ever used.
	logic [FB-1:0] qy_mag;
	logic [FB:0]   cone_base;
	assign qy_mag    = quot_sd[NST][1];
	assign cone_base = meta_sd[NST].neg[1] ? ((FB+1)'(1) << (FB-1)) + (FB+1)'(qy_mag)
		: ((FB+1)'(1) << (FB-1)) - (FB+1)'(qy_mag);

	logic [2*FB-1:0]   sq_s5 [3];
	logic [2*FB+1:0]   cone_rhs_s5;
	piupt_pkg::meta_t  meta_s5;
	logic              vld_s5;

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			sq_s5[a] <= quot_sd[NST][a] * quot_sd[NST][a];
		end
		cone_rhs_s5 <= cone_base * cone_base;
		meta_s5     <= meta_sd[NST];
	end

	// Final compare stage.
	localparam logic [2*FB+1:0] QUARTER_SQ = (2*FB+2)'(1) << (2*FB-2);

	logic [2*FB+1:0] sum_xz;
	logic [2*FB+1:0] sum_xyz;
	logic            kind_hit;
	logic            all_half_ok;

	assign sum_xz      = (2*FB+2)'(sq_s5[0]) + (2*FB+2)'(sq_s5[2]);
	assign sum_xyz     = sum_xz + (2*FB+2)'(sq_s5[1]);
	assign all_half_ok = &meta_s5.half_ok;

	always_comb begin
		case (meta_s5.kind)
			piupt_pkg::KIND_CUBE:     kind_hit = 1'b1;
			piupt_pkg::KIND_CONE:     kind_hit = {sum_xz[2*FB-1:0], 2'b00} < cone_rhs_s5;
			piupt_pkg::KIND_CYLINDER: kind_hit = sum_xz < QUARTER_SQ;
			piupt_pkg::KIND_SPHERE:   kind_hit = sum_xyz < QUARTER_SQ;
			default:                  kind_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		res_item.inside_res   <= kind_hit && all_half_ok && !meta_s5.w_zero;
		res_item.object_index <= meta_s5.obj;
		res_item.bad_kind     <= (meta_s5.kind > piupt_pkg::KIND_MESH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_sd    <= '0;
			vld_s5    <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_sd    <= {vld_sd[NST-1:0], vld_s2};
			vld_s5    <= vld_sd[NST];
			res_valid <= vld_s5;
		end
	end

endmodule

### tb/sv/point_in_unit_primitive_test_test.sv
// Testbench for the point-in-unit-primitive tester: directed and random objects checked against a predictor.
`timescale 1ns / 100ps

module point_in_unit_primitive_test_test;

	localparam int LATENCY = 21;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint HALF = 64'sd1 <<< (piupt_pkg::FRAC_BITS - 1);
	localparam longint QUARTER_SQ = 64'sd1 <<< (2 * piupt_pkg::FRAC_BITS - 2);
	localparam longint Q_SAT = 64'sd2147483647;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	piupt_pkg::in_item_t in_item = '0;
	logic res_valid;
	piupt_pkg::res_item_t res_item;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [31:0] query_point [4];
	piupt_pkg::res_item_t expected_hits [$];
	int fail_count = 0;
	longint cycle_count = 0;

	point_in_unit_primitive_test dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.res_valid(res_valid), .res_item(res_item), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL point_in_unit_primitive_test");
			$finish;
		end
	end

	function automatic longint floor_shift(longint p);
		return p >>> piupt_pkg::FRAC_BITS;
	endfunction

	function automatic longint fixed_quotient(longint n, longint d);
		longint un, ud, ip, r, mag;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		ip = un / ud;
		if (ip >= (64'sd1 <<< (31 - piupt_pkg::FRAC_BITS))) begin
			mag = Q_SAT;
		end else begin
			r = un % ud;
			mag = ip;
			for (int i = 0; i < piupt_pkg::FRAC_BITS; i++) begin
				r = r <<< 1;
				mag = mag <<< 1;
				if (r >= ud) begin
					r -= ud;
					mag |= 1;
				end
			end
		end
		return ((n < 0) != (d < 0)) ? -mag : mag;
	endfunction

	function automatic bit in_half(longint q);
		return q > -HALF && q < HALF;
	endfunction

	function automatic longint unsigned sq_mag(longint q);
		return q * q;
	endfunction

	function automatic piupt_pkg::res_item_t predict_containment(piupt_pkg::in_item_t it);
		logic [63:0] words [8];
		longint h [4];
		longint m, qx, qy, qz;
		logic [63:0] w;
		bit hit;
		piupt_pkg::res_item_t res;
		words = '{it.row0_left, it.row0_right, it.row1_left, it.row1_right,
			it.row2_left, it.row2_right, it.row3_left, it.row3_right};
		hit = 0;
		for (int r = 0; r < 4; r++) begin
			h[r] = 0;
			for (int c = 0; c < 4; c++) begin
				w = words[2 * r + c / 2];
				m = (c % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
				h[r] += floor_shift(m * longint'(signed'(query_point[c])));
			end
		end
		if (h[3] != 0 && it.primitive_kind <= piupt_pkg::KIND_SPHERE) begin
			qx = fixed_quotient(h[0], h[3]);
			qy = fixed_quotient(h[1], h[3]);
			qz = fixed_quotient(h[2], h[3]);
			case (it.primitive_kind)
				piupt_pkg::KIND_CUBE: hit = in_half(qx) && in_half(qy) && in_half(qz);
				piupt_pkg::KIND_CONE: begin
					if (in_half(qx) && in_half(qy) && in_half(qz))
						hit = 4 * (qx * qx + qz * qz) < (HALF - qy) * (HALF - qy);
				end
				piupt_pkg::KIND_CYLINDER:
					hit = in_half(qy) && (sq_mag(qx) + sq_mag(qz)) < QUARTER_SQ;
				default: begin
					hit = (sq_mag(qx) + sq_mag(qy) + sq_mag(qz)) < QUARTER_SQ;
				end
			endcase
		end
		res.inside_res = hit;
		res.object_index = it.object_number;
		res.bad_kind = it.primitive_kind > piupt_pkg::KIND_MESH;
		return res;
	endfunction

	always @(posedge clk) begin
		piupt_pkg::res_item_t want;
		if (arst_n && res_valid) begin
			if (expected_hits.size() == 0) begin
				$display("%0t unexpected result %p", $time, res_item);
				fail_count++;
			end else begin
				want = expected_hits.pop_front();
				if (res_item.inside_res !== want.inside_res) begin
					$display("%0t inside_res expected %0d actual %0d", $time,
						want.inside_res, res_item.inside_res);
					fail_count++;
				end
				if (res_item.object_index !== want.object_index) begin
					$display("%0t object_index expected %0d actual %0d", $time,
						want.object_index, res_item.object_index);
					fail_count++;
				end
				if (res_item.bad_kind !== want.bad_kind) begin
					$display("%0t bad_kind expected %0d actual %0d", $time,
						want.bad_kind, res_item.bad_kind);
					fail_count++;
				end
			end
		end
	end

	task automatic write_point(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		query_point[idx] = value;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_hits.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_object(piupt_pkg::in_item_t it, int gap);
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		expected_hits = {expected_hits, predict_containment(it)};
		if (gap > 0) begin
			start <= 1'b0;
			in_item <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, 19'($urandom)};
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_entry();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
			2: return 32'(1 << piupt_pkg::FRAC_BITS);
			3: return 32'h0;
			default: return 32'($urandom_range(0, 1 << 16)) - 32'(1 << 15);
		endcase
	endfunction

	// Mostly near-identity transforms with small offsets so that hits happen.
	function automatic piupt_pkg::in_item_t random_object(bit wild);
		logic [31:0] e [16];
		piupt_pkg::in_item_t it;
		for (int i = 0; i < 16; i++) begin
			if (wild)
				e[i] = random_entry();
			else if (i % 5 == 0)
				e[i] = 32'($urandom_range(1 << 15, 1 << 18));
			else if (i % 4 == 3 && i < 12)
				e[i] = 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
			else
				e[i] = ($urandom_range(0, 3) == 0) ? random_entry() : 32'h0;
		end
		it.row0_left = {e[1], e[0]};
		it.row0_right = {e[3], e[2]};
		it.row1_left = {e[5], e[4]};
		it.row1_right = {e[7], e[6]};
		it.row2_left = {e[9], e[8]};
		it.row2_right = {e[11], e[10]};
		it.row3_left = {e[13], e[12]};
		it.row3_right = {e[15], e[14]};
		it.primitive_kind = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 3))
			: 3'($urandom_range(0, 7));
		it.object_number = 16'($urandom);
		return it;
	endfunction

	function automatic piupt_pkg::in_item_t scaled_object(logic [2:0] kind, logic [31:0] off_x,
		logic [31:0] off_y, logic [31:0] off_z, logic [31:0] wv, logic [15:0] num);
		piupt_pkg::in_item_t it;
		it = '0;
		it.row0_left = {32'h0, 32'(1 << piupt_pkg::FRAC_BITS)};
		it.row0_right = {off_x, 32'h0};
		it.row1_left = {32'(1 << piupt_pkg::FRAC_BITS), 32'h0};
		it.row1_right = {off_y, 32'h0};
		it.row2_left = '0;
		it.row2_right = {off_z, 32'(1 << piupt_pkg::FRAC_BITS)};
		it.row3_right = {wv, 32'h0};
		it.primitive_kind = kind;
		it.object_number = num;
		return it;
	endfunction

	task automatic test_directed_shapes();
		piupt_pkg::in_item_t it;
		for (int k = 0; k < 8; k++) begin
			send_object(scaled_object(3'(k), 32'h0, 32'h0, 32'h0,
				32'(1 << piupt_pkg::FRAC_BITS), 16'(k)), 0);
			send_object(scaled_object(3'(k), 32'h0000_6000, 32'hFFFF_A000, 32'h0,
				32'(1 << piupt_pkg::FRAC_BITS), 16'hFFFF), 1);
		end
		send_object(scaled_object(piupt_pkg::KIND_CUBE, 32'h0, 32'h0, 32'h0, 32'h0,
			16'h1234), 0);
		send_object(scaled_object(piupt_pkg::KIND_SPHERE, 32'h0000_8000, 32'h0, 32'h0,
			32'(1 << piupt_pkg::FRAC_BITS), 16'h0), 0);
		send_object(scaled_object(piupt_pkg::KIND_CONE, 32'h0, 32'hFFFF_8001, 32'h0,
			32'(1 << piupt_pkg::FRAC_BITS), 16'h8000), 2);
		send_object(scaled_object(piupt_pkg::KIND_CYLINDER, 32'h7FFF_FFFF, 32'h0, 32'h0,
			32'h1, 16'h7), 0);
		it = '1;
		send_object(it, 0);
		it = '0;
		it.row3_left = {32'h8000_0000, 32'h8000_0000};
		it.row3_right = {32'h8000_0000, 32'h8000_0000};
		send_object(it, 0);
		drain_results();
	endtask

	task automatic test_random_objects(int count);
		for (int n = 0; n < count; n++)
			send_object(random_object($urandom_range(0, 4) == 0),
				($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6));
		drain_results();
	endtask

	task automatic test_point_settings();
		logic [31:0] extremes [4];
		extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
		for (int s = 0; s < 4; s++) begin
			write_point(piupt_pkg::REG_POINT_X, extremes[s]);
			write_point(piupt_pkg::REG_POINT_Y, extremes[(s + 1) % 4]);
			write_point(piupt_pkg::REG_POINT_Z, extremes[(s + 2) % 4]);
			write_point(piupt_pkg::REG_POINT_W, extremes[(s + 3) % 4]);
			test_random_objects(60);
		end
		for (int s = 0; s < 6; s++) begin
			write_point(piupt_pkg::REG_POINT_X, 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16));
			write_point(piupt_pkg::REG_POINT_Y, 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16));
			write_point(piupt_pkg::REG_POINT_Z, 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16));
			write_point(piupt_pkg::REG_POINT_W, (s == 5) ? $urandom
				: 32'($urandom_range(1 << 15, 1 << 17)));
			test_random_objects(150);
		end
	endtask

	initial begin
		query_point = '{32'h0, 32'h0, 32'h0, piupt_pkg::POINT_W_RESET};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_shapes();
		test_random_objects(800);
		test_point_settings();
		if (fail_count == 0)
			$display("PASS point_in_unit_primitive_test");
		else
			$display("FAIL point_in_unit_primitive_test");
		$finish;
	end

endmodule
